/* design/unordered_value_table_macros.svh */
// assertion helpers for the checker
`ifndef UNORDERED_VALUE_TABLE_MACROS_SVH
`define UNORDERED_VALUE_TABLE_MACROS_SVH

// same-cycle implication, clocked on clock and quiet during reset
`define UVT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uvt check failed");

// next-cycle implication
`define UVT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uvt check failed");

`endif

/* design/uvt_pkg.sv */
`default_nettype none

package uvt_pkg;

   localparam int CAPACITY_DEFAULT = 128;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 7;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 8;

   localparam logic [CMD_W-1:0] CMD_APPEND       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE_FIRST = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE_AT    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE_ALL   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

endpackage

`default_nettype wire

/* design/unordered_value_table.sv */
`default_nettype none

// Dense, order-preserving table of up to CAPACITY signed 32-bit values held in one
// synchronous memory (one write port, one registered read port). One request is
// worked at a time and gives one response. Append, an unknown command and any
// command answered from the entry count alone (full, empty, index out of range)
// are settled on acceptance and pass through S_DONE to the output register. Search
// and the three removals walk the valid entries through the single read port, one
// entry per cycle, and compact in place through the write port. A new request is
// taken once the previous result sits in the output register.
module unordered_value_table #(
   parameter int CAPACITY = uvt_pkg::CAPACITY_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [uvt_pkg::CMD_W-1:0]        req_command,
   input  wire  signed [uvt_pkg::VALUE_W-1:0] req_value,
   input  wire  [uvt_pkg::INDEX_W-1:0]      req_index,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [uvt_pkg::STATUS_W-1:0]     rsp_status,
   output logic [uvt_pkg::INDEX_W-1:0]      rsp_found_index,
   output logic [uvt_pkg::COUNT_W-1:0]      rsp_removed_count,
   output logic [uvt_pkg::COUNT_W-1:0]      rsp_entry_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic [uvt_pkg::CMD_W-1:0]        cmd_ff, cmd_in;
   logic [uvt_pkg::VALUE_W-1:0]      value_ff, value_in;
   logic [uvt_pkg::INDEX_W-1:0]      index_ff, index_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]                    wr_ptr_ff, wr_ptr_in;
   logic                             chk_vld_ff, chk_vld_in;
   logic [AW-1:0]                    chk_pos_ff, chk_pos_in;
   logic                             hit_ff, hit_in;
   logic [AW-1:0]                    hit_pos_ff, hit_pos_in;
   logic [uvt_pkg::STATUS_W-1:0]     res_status_ff, res_status_in;
   logic [uvt_pkg::INDEX_W-1:0]      res_found_ff, res_found_in;
   logic [uvt_pkg::COUNT_W-1:0]      res_removed_ff, res_removed_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [uvt_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [uvt_pkg::INDEX_W-1:0]      rsp_found_ff, rsp_found_in;
   logic [uvt_pkg::COUNT_W-1:0]      rsp_removed_ff, rsp_removed_in;
   logic [uvt_pkg::COUNT_W-1:0]      rsp_entry_ff, rsp_entry_in;

   logic [uvt_pkg::VALUE_W-1:0]      entries_ff [CAPACITY];
   logic [uvt_pkg::VALUE_W-1:0]      rd_data_ff;

   logic                             mem_we;
   logic [AW-1:0]                    mem_wa;
   logic [uvt_pkg::VALUE_W-1:0]      mem_wd;
   logic [AW-1:0]                    mem_ra;

   logic                             accept;
   logic                             issue;
   logic                             out_free;
   logic                             match;
   logic                             drop;
   logic                             is_remove;
   logic                             is_lookup;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign issue     = (state_ff == S_SCAN) && (rd_ptr_ff < count_ff);
   assign match     = (rd_data_ff == value_ff);
   assign is_remove = (cmd_ff != uvt_pkg::CMD_SEARCH);
   assign is_lookup = (cmd_ff == uvt_pkg::CMD_SEARCH) || (cmd_ff == uvt_pkg::CMD_REMOVE_FIRST);
   assign mem_ra    = rd_ptr_ff[AW-1:0];

   always_comb begin
      case (cmd_ff)
         uvt_pkg::CMD_REMOVE_FIRST: drop = match && !hit_ff;
         uvt_pkg::CMD_REMOVE_AT:    drop = (32'(chk_pos_ff) == 32'(index_ff));
         uvt_pkg::CMD_REMOVE_ALL:   drop = match;
         default:                   drop = 1'b0;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      value_in       = value_ff;
      index_in       = index_ff;
      count_in       = count_ff;
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      chk_vld_in     = 1'b0;
      chk_pos_in     = rd_ptr_ff[AW-1:0];
      hit_in         = hit_ff;
      hit_pos_in     = hit_pos_ff;
      res_status_in  = res_status_ff;
      res_found_in   = res_found_ff;
      res_removed_in = res_removed_ff;
      mem_we         = 1'b0;
      mem_wa         = wr_ptr_ff[AW-1:0];
      mem_wd         = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in         = req_command;
               value_in       = req_value;
               index_in       = req_index;
               rd_ptr_in      = '0;
               wr_ptr_in      = '0;
               hit_in         = 1'b0;
               hit_pos_in     = '0;
               res_status_in  = uvt_pkg::ST_DONE;
               res_found_in   = '0;
               res_removed_in = '0;
               state_in       = S_DONE;
               case (req_command)
                  uvt_pkg::CMD_APPEND: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        res_status_in = uvt_pkg::ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        mem_wa   = count_ff[AW-1:0];
                        mem_wd   = req_value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  uvt_pkg::CMD_SEARCH, uvt_pkg::CMD_REMOVE_FIRST: begin
                     state_in = S_SCAN;
                  end
                  uvt_pkg::CMD_REMOVE_AT: begin
                     if (count_ff == '0) begin
                        res_status_in = uvt_pkg::ST_EMPTY;
                     end else if (32'(req_index) >= 32'(count_ff)) begin
                        res_status_in = uvt_pkg::ST_RANGE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  uvt_pkg::CMD_REMOVE_ALL: begin
                     if (count_ff == '0) begin
                        res_status_in = uvt_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // read runs one entry ahead of the compare; writes land only behind it
            chk_vld_in = issue;
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end
            if (chk_vld_ff) begin
               if (match && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_pos_in = chk_pos_ff;
               end
               if (is_remove && !drop) begin
                  mem_we    = 1'b1;
                  wr_ptr_in = wr_ptr_ff + CW'(1);
               end
            end
            if (!issue && !chk_vld_ff) begin
               state_in = S_DONE;
               if (is_lookup && !hit_ff) begin
                  res_status_in = uvt_pkg::ST_NOTFOUND;
               end
               if (is_lookup && hit_ff) begin
                  res_found_in = 7'(hit_pos_ff);
               end
               if (is_remove) begin
                  res_removed_in = 8'(count_ff - wr_ptr_ff);
                  count_in       = wr_ptr_ff;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_entry_in   = rsp_entry_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
         if (state_ff == S_DONE) begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = res_status_ff;
            rsp_found_in   = res_found_ff;
            rsp_removed_in = res_removed_ff;
            rsp_entry_in   = 8'(count_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      value_ff       <= value_in;
      index_ff       <= index_in;
      rd_ptr_ff      <= rd_ptr_in;
      wr_ptr_ff      <= wr_ptr_in;
      chk_pos_ff     <= chk_pos_in;
      hit_ff         <= hit_in;
      hit_pos_ff     <= hit_pos_in;
      res_status_ff  <= res_status_in;
      res_found_ff   <= res_found_in;
      res_removed_ff <= res_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_entry_ff   <= rsp_entry_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= entries_ff[mem_ra];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_index   = rsp_found_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_entry_count   = rsp_entry_ff;

endmodule

`default_nettype wire

/* design/uvt_checker.sv */
`default_nettype none

`include "unordered_value_table_macros.svh"

module uvt_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input wire [uvt_pkg::CMD_W-1:0]     req_command,
   input wire [uvt_pkg::VALUE_W-1:0]   req_value,
   input wire [uvt_pkg::INDEX_W-1:0]   req_index,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire [uvt_pkg::STATUS_W-1:0]  rsp_status,
   input wire [uvt_pkg::INDEX_W-1:0]   rsp_found_index,
   input wire [uvt_pkg::COUNT_W-1:0]   rsp_removed_count,
   input wire [uvt_pkg::COUNT_W-1:0]   rsp_entry_count
);

   // a stalled request keeps its payload
   `UVT_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_command) && $stable(req_value) && $stable(req_index))

   // a stalled response keeps its status and counts
   `UVT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count) && $stable(rsp_removed_count))

   // one request in flight: the port closes right after a request is taken
   `UVT_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)

   // a failed command never removes anything
   `UVT_ASSERT_NOW(a_fail_no_remove, rsp_valid && (rsp_status != uvt_pkg::ST_DONE), rsp_removed_count == '0)

   // a miss reports no position
   `UVT_ASSERT_NOW(a_miss_no_index, rsp_valid && (rsp_status == uvt_pkg::ST_NOTFOUND), rsp_found_index == '0)

endmodule

bind unordered_value_table uvt_checker u_uvt_checker (.*);

`default_nettype wire
